// File: rtl/rtmt_pkg.sv
// Package for the release-time makespan tree: node types, constants and the
// node merge function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtmt_pkg;

   localparam int TOTAL_W = 40;
   localparam int SLACK_W = 42;
   localparam int SLOT_W = 10;
   localparam int DELTA_W = 17;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // One tree node: saturating processing-time total and the signed slack,
   // which has meaning only while valid is set.
   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic [SLACK_W-1:0] slack;
      logic               valid;
   } node_type;

   // The two children of one node, left in lo and right in hi.
   typedef struct packed {
      node_type lo;
      node_type hi;
   } pair_type;

   localparam node_type NODE_EMPTY = '{total: '0, slack: '0, valid: 1'b0};

   function automatic node_type merge_node(input pair_type p);
      node_type                   n;
      logic [TOTAL_W:0]           sum;
      logic signed [SLACK_W-1:0]  cand;
      sum = {1'b0, p.lo.total} + {1'b0, p.hi.total};
      n.total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
      cand = $signed(p.hi.slack) - $signed({2'b00, p.lo.total});
      n.valid = p.lo.valid | p.hi.valid;
      if (p.lo.valid && p.hi.valid) begin
         n.slack = (cand > $signed(p.lo.slack)) ? cand : p.lo.slack;
      end else if (p.lo.valid) begin
         n.slack = p.lo.slack;
      end else if (p.hi.valid) begin
         n.slack = cand;
      end else begin
         n.slack = '0;
      end
      return n;
   endfunction

   // Root total plus the positive part of the root slack, saturated.
   function automatic logic [TOTAL_W-1:0] finish_of(input node_type n);
      logic [TOTAL_W:0] sum;
      sum = {1'b0, n.total};
      if (n.valid && $signed(n.slack) > 0) begin
         sum = sum + {1'b0, n.slack[TOTAL_W-1:0]};
      end
      return sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/release_time_makespan_tree.sv
// Top level of the release-time makespan tree: the chain of level cells, the
// root node and the result register. Depends on rtmt_pkg and rtmt_cell.
//
// Usage: each item on the req_ channel carries a release slot and a signed
// processing-time change. The block updates that slot's leaf, rebuilds the
// path to the root one tree level per cycle, and returns one rsp_ item with
// the earliest finish time of all pending jobs and an underflow flag.
// One item is in flight at a time, so a new item is taken only after the
// previous one's result has moved to the output register. The update token
// walks through one cell per tree level, then the root stage and the output
// register. After reset the block clears every level store, one entry of
// each level per cycle, while a counter steps through every leaf address;
// req_ready stays low for that time.
// A finished result waits in the output register; the next item is still
// accepted, and its result waits at the root until the output is taken.
`timescale 1ns / 1ps
`default_nettype none

module release_time_makespan_tree import rtmt_pkg::*; #(
   parameter int SLOTS = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [SLOT_W-1:0]          req_slot,
   input  wire logic signed [DELTA_W-1:0]  req_delta,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [TOTAL_W-1:0]              rsp_finish_time,
   output logic                            rsp_underflow
);

   localparam int LEAF_W = $clog2(SLOTS);

   logic                       accept;
   logic [LEAF_W+SLOT_W-1:0]   slot_ext;
   logic [LEAF_W-1:0]          idx_req;
   logic                       inr_req;

   logic [LEAF_W-1:0]          idx_ff;
   logic signed [DELTA_W-1:0]  delta_ff;
   logic                       inr_ff;
   logic                       start_ff;
   logic                       busy_ff, busy_in;
   logic                       clearing_ff;
   logic [LEAF_W-1:0]          clr_cnt_ff;
   logic                       pend_ff;
   node_type                   root_in;
   logic                       load;
   logic                       rsp_valid_ff;
   logic [TOTAL_W-1:0]         finish_ff;
   logic                       underflow_ff;

   logic     tok   [LEAF_W+1];
   pair_type pair  [LEAF_W+1];
   logic     flag  [LEAF_W+1];

   assign accept = req_valid && req_ready;
   assign slot_ext = {{LEAF_W{1'b0}}, req_slot};
   assign idx_req = slot_ext[LEAF_W-1:0];
   assign inr_req = 21'(req_slot) < 21'(SLOTS);

   // Level LEAF_W holds the leaves; the token enters there and walks to level 1.
   assign tok[LEAF_W + 0] = 1'b0;
   assign pair[LEAF_W + 0] = '0;
   assign flag[LEAF_W + 0] = 1'b0;

   generate
      for (genvar k = 1; k <= LEAF_W; k++) begin : g_level
         rtmt_cell #(
            .LEVEL  (k),
            .LEAF_W (LEAF_W)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .start      (accept),
            .start_idx  (idx_req),
            .leaf_idx   (idx_ff),
            .delta      (delta_ff),
            .in_range   (inr_ff),
            .clear      (clearing_ff),
            .clear_addr (clr_cnt_ff),
            .tok_in     ((k == LEAF_W) ? start_ff : tok[k]),
            .pair_in    ((k == LEAF_W) ? pair[LEAF_W] : pair[k]),
            .tok_out    (tok[k-1]),
            .pair_out   (pair[k-1]),
            .flag_out   (flag[k-1])
         );
      end
   endgenerate

   assign root_in = merge_node(pair[0]);
   assign load = pend_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (load) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b0;
         busy_ff <= 1'b0;
         clearing_ff <= 1'b1;
         clr_cnt_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= accept;
         busy_ff <= busy_in;
         if (clearing_ff) begin
            clr_cnt_ff <= clr_cnt_ff + LEAF_W'(1);
            if (clr_cnt_ff == '1) begin
               clearing_ff <= 1'b0;
            end
         end
         if (tok[0]) begin
            pend_ff <= 1'b1;
         end else if (load) begin
            pend_ff <= 1'b0;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         idx_ff <= idx_req;
         delta_ff <= req_delta;
         inr_ff <= inr_req;
      end
      if (load) begin
         finish_ff <= finish_of(root_in);
         underflow_ff <= flag[LEAF_W-1];
      end
   end

   assign req_ready = !busy_ff && !clearing_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_finish_time = finish_ff;
   assign rsp_underflow = underflow_ff;

endmodule

`default_nettype wire

// File: rtl/rtmt_cell.sv
// One tree level of the release-time makespan tree: the node store of that
// level, its sibling read and its update. Depends on rtmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtmt_cell import rtmt_pkg::*; #(
   parameter int LEVEL = 1,
   parameter int LEAF_W = 10
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [LEAF_W-1:0]   start_idx,
   input  wire logic [LEAF_W-1:0]   leaf_idx,
   input  wire logic signed [DELTA_W-1:0] delta,
   input  wire logic                in_range,
   input  wire logic                clear,
   input  wire logic [LEAF_W-1:0]   clear_addr,
   input  wire logic                tok_in,
   input  wire pair_type            pair_in,
   output logic                     tok_out,
   output pair_type                 pair_out,
   output logic                     flag_out
);

   localparam int ENTRIES = 2 ** LEVEL;

   node_type mem [ENTRIES];
   node_type sib_ff;
   node_type self_ff;
   node_type node_in;
   logic     flag_in;
   logic     tok_ff;
   pair_type pair_ff;
   logic     flag_ff;

   logic [LEVEL-1:0] rd_idx;
   logic [LEVEL-1:0] wr_idx;
   logic signed [SLACK_W-1:0] sum;

   assign rd_idx = start_idx[LEAF_W-1 -: LEVEL];
   assign wr_idx = leaf_idx[LEAF_W-1 -: LEVEL];

   always_ff @(posedge clock) begin
      if (start) begin
         sib_ff <= mem[rd_idx ^ LEVEL'(1)];
         self_ff <= mem[rd_idx];
      end
      if (clear) begin
         mem[clear_addr[LEVEL-1:0]] <= NODE_EMPTY;
      end else if (tok_in) begin
         mem[wr_idx] <= node_in;
      end
   end

   always_comb begin
      sum = $signed({2'b00, self_ff.total}) + {{(SLACK_W-DELTA_W){delta[DELTA_W-1]}}, delta};
      node_in = self_ff;
      flag_in = 1'b0;
      if (LEVEL == LEAF_W) begin
         // A slot beyond the used range leaves its leaf, and so the tree, as it is.
         if (in_range) begin
            if (sum < 0) begin
               node_in.total = '0;
               flag_in = 1'b1;
            end else if (sum > $signed({2'b00, TOTAL_MAX})) begin
               node_in.total = TOTAL_MAX;
            end else begin
               node_in.total = sum[TOTAL_W-1:0];
            end
            node_in.valid = (node_in.total != '0);
            node_in.slack = node_in.valid ? SLACK_W'(wr_idx) : '0;
         end
      end else begin
         node_in = merge_node(pair_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
         flag_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
         if (tok_in && LEVEL == LEAF_W) begin
            flag_ff <= flag_in;
         end
      end
      if (tok_in) begin
         if (wr_idx[0]) begin
            pair_ff <= '{lo: sib_ff, hi: node_in};
         end else begin
            pair_ff <= '{lo: node_in, hi: sib_ff};
         end
      end
   end

   assign tok_out = tok_ff;
   assign pair_out = pair_ff;
   assign flag_out = flag_ff;

endmodule

`default_nettype wire

// File: rtl/rtmt_checker.sv
// Port-level checks for the release-time makespan tree, bound to its top
// level. Depends on rtmt_pkg and release_time_makespan_tree.
`timescale 1ns / 1ps
`default_nettype none

module rtmt_checker import rtmt_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [TOTAL_W-1:0]  rsp_finish_time,
   input wire logic                rsp_underflow
);

   // The store clearing pass keeps the input closed right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high right after reset");

   // Only one item is in flight: an accepted item closes the input.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item accepted while one is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_finish_time) && $stable(rsp_underflow)))
      else $error("result item changed while stalled");

endmodule

bind release_time_makespan_tree rtmt_checker u_rtmt_checker (.*);

`default_nettype wire

// File: test/tb.sv
// Testbench for release_time_makespan_tree: a directed table of job changes, then random
// ones, each checked against a behavioral copy of the slot tree. Depends on rtmt_pkg.
`timescale 1ns / 1ps

module tb;
   import rtmt_pkg::*;

   localparam int NSLOTS = 1024;
   localparam int LEAVES = 1024;
   localparam longint TMAX = (64'd1 << 40) - 1;

   typedef struct {
      logic [SLOT_W-1:0]         slot;
      logic signed [DELTA_W-1:0] delta;
      bit                        known;
      logic [TOTAL_W-1:0]        fin;
      logic                      uf;
   } stim_type;

   typedef struct {
      logic [TOTAL_W-1:0] fin;
      logic               uf;
   } finish_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [SLOT_W-1:0] req_slot = '0;
   logic signed [DELTA_W-1:0] req_delta = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [TOTAL_W-1:0] rsp_finish_time;
   logic rsp_underflow;

   release_time_makespan_tree #(.SLOTS(NSLOTS)) dut (.*);

   always #5 clock = ~clock;

   // Behavioral tree, heap numbered with the root at 1.
   longint tree_total [2*LEAVES];
   longint tree_slack [2*LEAVES];
   bit     tree_valid [2*LEAVES];
   finish_type pending_finish[$];
   int errors = 0;
   bit hold_rsp = 1'b0;

   function automatic longint clamp_total(longint v);
      return (v > TMAX) ? TMAX : v;
   endfunction

   function automatic finish_type apply_change(logic [SLOT_W-1:0] slot,
                                               logic signed [DELTA_W-1:0] delta);
      finish_type r;
      int p;
      int lc;
      longint t;
      longint cand;
      r.uf = 1'b0;
      if (slot < NSLOTS) begin
         p = LEAVES + slot;
         t = tree_total[p] + longint'(delta);
         if (t < 0) begin
            t = 0;
            r.uf = 1'b1;
         end
         t = clamp_total(t);
         tree_total[p] = t;
         tree_valid[p] = (t > 0);
         tree_slack[p] = (t > 0) ? longint'(slot) : 0;
         for (p = p / 2; p >= 1; p = p / 2) begin
            lc = 2 * p;
            tree_total[p] = clamp_total(tree_total[lc] + tree_total[lc+1]);
            cand = tree_slack[lc+1] - tree_total[lc];
            tree_valid[p] = tree_valid[lc] | tree_valid[lc+1];
            if (tree_valid[lc] && tree_valid[lc+1])
               tree_slack[p] = (cand > tree_slack[lc]) ? cand : tree_slack[lc];
            else if (tree_valid[lc])
               tree_slack[p] = tree_slack[lc];
            else if (tree_valid[lc+1])
               tree_slack[p] = cand;
            else
               tree_slack[p] = 0;
         end
      end
      t = tree_total[1];
      if (tree_valid[1] && tree_slack[1] > 0) t = clamp_total(t + tree_slack[1]);
      r.fin = t[TOTAL_W-1:0];
      return r;
   endfunction

   task automatic send_change(stim_type s);
      finish_type e;
      req_slot <= s.slot;
      req_delta <= s.delta;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      e = apply_change(s.slot, s.delta);
      if (s.known && (e.fin !== s.fin || e.uf !== s.uf)) begin
         $display("%0t table row slot %0d: expected fin %0d uf %0b, model fin %0d uf %0b",
                  $time, s.slot, s.fin, s.uf, e.fin, e.uf);
         errors++;
      end
      pending_finish.insert(pending_finish.size(), e);
   endtask

   task automatic sender_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Receiver with random stalls, plus a long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (pending_finish.size() == 0) begin
               $display("%0t unexpected result fin %0d", $time, rsp_finish_time);
               errors++;
            end else begin
               finish_type e;
               e = pending_finish.pop_front();
               if (rsp_finish_time !== e.fin) begin
                  $display("%0t finish_time expected %0d actual %0d",
                           $time, e.fin, rsp_finish_time);
                  errors++;
               end
               if (rsp_underflow !== e.uf) begin
                  $display("%0t underflow expected %0b actual %0b",
                           $time, e.uf, rsp_underflow);
                  errors++;
               end
            end
         end
         if (hold_rsp)
            rsp_ready <= 1'b0;
         else if ($urandom_range(0, 19) == 0)
            rsp_ready <= 1'b0;
         else
            rsp_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
      end
   end

   initial begin
      #50_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   stim_type dir_tab[] = '{
      '{10'd5, 17'sd0, 1'b1, 40'd0, 1'b0},
      '{10'd0, -17'sd1, 1'b1, 40'd0, 1'b1},
      '{10'd0, 17'sd7, 1'b1, 40'd7, 1'b0},
      '{10'd100, 17'sd3, 1'b1, 40'd103, 1'b0},
      '{10'd1023, 17'sd65535, 1'b0, 40'd0, 1'b0},
      '{10'd1023, -17'sd65535, 1'b0, 40'd0, 1'b0},
      '{10'd1023, -17'sd65536, 1'b1, 40'd103, 1'b1},
      '{10'd100, -17'sd3, 1'b1, 40'd7, 1'b0},
      '{10'd0, -17'sd7, 1'b1, 40'd0, 1'b0},
      '{10'd512, 17'sd65535, 1'b0, 40'd0, 1'b0},
      '{10'd511, 17'sd1, 1'b0, 40'd0, 1'b0},
      '{10'd513, -17'sd65536, 1'b0, 40'd0, 1'b0},
      '{10'd0, 17'sd65535, 1'b0, 40'd0, 1'b0},
      '{10'd700, -17'sd2, 1'b0, 40'd0, 1'b0},
      '{10'd512, -17'sd65535, 1'b0, 40'd0, 1'b0},
      '{10'd0, -17'sd65535, 1'b0, 40'd0, 1'b0},
      '{10'd511, -17'sd1, 1'b1, 40'd0, 1'b0}
   };

   initial begin
      stim_type s;
      for (int i = 0; i < 2 * LEAVES; i++) begin
         tree_total[i] = 0;
         tree_slack[i] = 0;
         tree_valid[i] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_tab[i]) begin
         send_change(dir_tab[i]);
         sender_gap();
      end
      for (int i = 0; i < 1950; i++) begin
         // Long receiver hold-off while the sender keeps offering items.
         if (i == 400) begin
            hold_rsp = 1'b1;
            fork
               begin
                  repeat (300) @(posedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
         end
         if (i == 1000) begin
            req_valid <= 1'b0;
            wait (pending_finish.size() == 0);
            @(posedge clock);
         end
         s.known = 1'b0;
         s.fin = '0;
         s.uf = 1'b0;
         // Mostly a small active set of slots so totals build up and drain.
         case ($urandom_range(0, 9))
            0: s.slot = SLOT_W'($urandom_range(0, 1023));
            1: s.slot = SLOT_W'(1023 - $urandom_range(0, 3));
            default: s.slot = SLOT_W'($urandom_range(0, 15) * 64 + $urandom_range(0, 3));
         endcase
         case ($urandom_range(0, 5))
            0: s.delta = DELTA_W'($urandom);
            1: s.delta = ($urandom_range(0, 1) != 0) ? 17'sd65535 : -17'sd65536;
            2, 3: s.delta = DELTA_W'($urandom_range(1, 5000));
            default: s.delta = -$signed({1'b0, 16'($urandom_range(1, 6000))});
         endcase
         send_change(s);
         sender_gap();
      end
      req_valid <= 1'b0;
      wait (pending_finish.size() == 0);
      repeat (30) @(posedge clock);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
